@@ hw/rtl/ctes_pkg.sv @@
// shared types, constants and tables for the cross-track error statistics block
package ctes_pkg;

    localparam int CORDIC_STEPS = 30;
    localparam int MUL_STEPS    = 36;
    localparam int DIV_STEPS    = 64;
    localparam int SQRT_STEPS   = 32;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic [30:0] MAX31 = 31'h7FFF_FFFF;

    typedef enum logic [1:0] {
        MODE_UPDATE = 2'd0,
        MODE_DIST   = 2'd1,
        MODE_CLEAR  = 2'd2,
        MODE_NONE   = 2'd3
    } mode_t;

    typedef enum logic [4:0] {
        OP_IDLE,
        OP_LOAD,
        OP_CORDIC_INIT,
        OP_CORDIC_STEP,
        OP_MUL_A_INIT,
        OP_MUL_B_INIT,
        OP_MUL_STEP,
        OP_STAT1,
        OP_DIV_STEP,
        OP_STAT2,
        OP_STAT3,
        OP_DX_INIT,
        OP_DY_INIT,
        OP_DIST_SUM,
        OP_SQRT_STEP,
        OP_DIST_SAVE,
        OP_CLEAR,
        OP_DEV_ZERO,
        OP_DEV_DIV_INIT,
        OP_DEV_SQRT_INIT,
        OP_DEV_SAVE,
        OP_OUT_LOAD
    } op_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CORDIC_INIT,
        S_CORDIC,
        S_MUL_A_INIT,
        S_MUL_A,
        S_MUL_B_INIT,
        S_MUL_B,
        S_STAT1,
        S_DIV_MEAN,
        S_STAT2,
        S_MUL_C,
        S_STAT3,
        S_DX_INIT,
        S_MUL_DX,
        S_DY_INIT,
        S_MUL_DY,
        S_DIST_SUM,
        S_SQRT_DIST,
        S_DIST_SAVE,
        S_CLEAR,
        S_DEV,
        S_DIV_DEV,
        S_SQRT_DEV_INIT,
        S_SQRT_DEV,
        S_DEV_SAVE,
        S_OUT
    } state_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic cordic_last;
        logic mul_last;
        logic div_last;
        logic sqrt_last;
        logic count_zero;
    } stat_t;

    function automatic logic [31:0] atan_turn(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'h2000_0000;
            5'd1:  v = 32'h12E4_051E;
            5'd2:  v = 32'h09FB_385B;
            5'd3:  v = 32'h0511_11D4;
            5'd4:  v = 32'h028B_0D43;
            5'd5:  v = 32'h0145_D7E1;
            5'd6:  v = 32'h00A2_F61E;
            5'd7:  v = 32'h0051_7C55;
            5'd8:  v = 32'h0028_BE53;
            5'd9:  v = 32'h0014_5F2F;
            5'd10: v = 32'h000A_2F98;
            5'd11: v = 32'h0005_17CC;
            5'd12: v = 32'h0002_8BE6;
            5'd13: v = 32'h0001_45F3;
            5'd14: v = 32'h0000_A2FA;
            5'd15: v = 32'h0000_517D;
            5'd16: v = 32'h0000_28BE;
            5'd17: v = 32'h0000_145F;
            5'd18: v = 32'h0000_0A30;
            5'd19: v = 32'h0000_0518;
            5'd20: v = 32'h0000_028C;
            5'd21: v = 32'h0000_0146;
            5'd22: v = 32'h0000_00A3;
            5'd23: v = 32'h0000_0051;
            5'd24: v = 32'h0000_0029;
            5'd25: v = 32'h0000_0014;
            5'd26: v = 32'h0000_000A;
            5'd27: v = 32'h0000_0005;
            5'd28: v = 32'h0000_0003;
            5'd29: v = 32'h0000_0001;
            default: v = 32'h0000_0000;
        endcase
        return v;
    endfunction

    function automatic logic [30:0] sat31(input logic [63:0] v);
        logic [30:0] r;
        if (v > 64'(MAX31))
            r = MAX31;
        else
            r = v[30:0];
        return r;
    endfunction

endpackage

@@ hw/rtl/ctes_ctrl.sv @@
// sequencer for the cross-track error statistics block
module ctes_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  logic [1:0]      mode,
    output logic            out_valid,
    input  logic            out_stall,
    input  ctes_pkg::stat_t stat,
    output ctes_pkg::cmd_t  cmd
);

    ctes_pkg::state_t state_reg;
    ctes_pkg::state_t state_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             accept;
    logic             out_free;

    assign in_stall  = (state_reg != ctes_pkg::S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ctes_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ctes_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    case (mode)
                        ctes_pkg::MODE_UPDATE: state_next = ctes_pkg::S_CORDIC_INIT;
                        ctes_pkg::MODE_DIST:   state_next = ctes_pkg::S_DX_INIT;
                        ctes_pkg::MODE_CLEAR:  state_next = ctes_pkg::S_CLEAR;
                        default:               state_next = ctes_pkg::S_DEV;
                    endcase
                end
            end
            ctes_pkg::S_CORDIC_INIT: state_next = ctes_pkg::S_CORDIC;
            ctes_pkg::S_CORDIC:
            begin
                if (stat.cordic_last)
                    state_next = ctes_pkg::S_MUL_A_INIT;
            end
            ctes_pkg::S_MUL_A_INIT:  state_next = ctes_pkg::S_MUL_A;
            ctes_pkg::S_MUL_A:
            begin
                if (stat.mul_last)
                    state_next = ctes_pkg::S_MUL_B_INIT;
            end
            ctes_pkg::S_MUL_B_INIT:  state_next = ctes_pkg::S_MUL_B;
            ctes_pkg::S_MUL_B:
            begin
                if (stat.mul_last)
                    state_next = ctes_pkg::S_STAT1;
            end
            ctes_pkg::S_STAT1:       state_next = ctes_pkg::S_DIV_MEAN;
            ctes_pkg::S_DIV_MEAN:
            begin
                if (stat.div_last)
                    state_next = ctes_pkg::S_STAT2;
            end
            ctes_pkg::S_STAT2:       state_next = ctes_pkg::S_MUL_C;
            ctes_pkg::S_MUL_C:
            begin
                if (stat.mul_last)
                    state_next = ctes_pkg::S_STAT3;
            end
            ctes_pkg::S_STAT3:       state_next = ctes_pkg::S_DEV;
            ctes_pkg::S_DX_INIT:     state_next = ctes_pkg::S_MUL_DX;
            ctes_pkg::S_MUL_DX:
            begin
                if (stat.mul_last)
                    state_next = ctes_pkg::S_DY_INIT;
            end
            ctes_pkg::S_DY_INIT:     state_next = ctes_pkg::S_MUL_DY;
            ctes_pkg::S_MUL_DY:
            begin
                if (stat.mul_last)
                    state_next = ctes_pkg::S_DIST_SUM;
            end
            ctes_pkg::S_DIST_SUM:    state_next = ctes_pkg::S_SQRT_DIST;
            ctes_pkg::S_SQRT_DIST:
            begin
                if (stat.sqrt_last)
                    state_next = ctes_pkg::S_DIST_SAVE;
            end
            ctes_pkg::S_DIST_SAVE:   state_next = ctes_pkg::S_DEV;
            ctes_pkg::S_CLEAR:       state_next = ctes_pkg::S_DEV;
            ctes_pkg::S_DEV:
            begin
                if (stat.count_zero)
                    state_next = ctes_pkg::S_OUT;
                else
                    state_next = ctes_pkg::S_DIV_DEV;
            end
            ctes_pkg::S_DIV_DEV:
            begin
                if (stat.div_last)
                    state_next = ctes_pkg::S_SQRT_DEV_INIT;
            end
            ctes_pkg::S_SQRT_DEV_INIT: state_next = ctes_pkg::S_SQRT_DEV;
            ctes_pkg::S_SQRT_DEV:
            begin
                if (stat.sqrt_last)
                    state_next = ctes_pkg::S_DEV_SAVE;
            end
            ctes_pkg::S_DEV_SAVE:    state_next = ctes_pkg::S_OUT;
            ctes_pkg::S_OUT:
            begin
                if (out_free)
                    state_next = ctes_pkg::S_IDLE;
            end
            default:                 state_next = ctes_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd.op         = ctes_pkg::OP_IDLE;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            ctes_pkg::S_IDLE:
            begin
                if (accept)
                    cmd.op = ctes_pkg::OP_LOAD;
            end
            ctes_pkg::S_CORDIC_INIT:   cmd.op = ctes_pkg::OP_CORDIC_INIT;
            ctes_pkg::S_CORDIC:        cmd.op = ctes_pkg::OP_CORDIC_STEP;
            ctes_pkg::S_MUL_A_INIT:    cmd.op = ctes_pkg::OP_MUL_A_INIT;
            ctes_pkg::S_MUL_A:         cmd.op = ctes_pkg::OP_MUL_STEP;
            ctes_pkg::S_MUL_B_INIT:    cmd.op = ctes_pkg::OP_MUL_B_INIT;
            ctes_pkg::S_MUL_B:         cmd.op = ctes_pkg::OP_MUL_STEP;
            ctes_pkg::S_STAT1:         cmd.op = ctes_pkg::OP_STAT1;
            ctes_pkg::S_DIV_MEAN:      cmd.op = ctes_pkg::OP_DIV_STEP;
            ctes_pkg::S_STAT2:         cmd.op = ctes_pkg::OP_STAT2;
            ctes_pkg::S_MUL_C:         cmd.op = ctes_pkg::OP_MUL_STEP;
            ctes_pkg::S_STAT3:         cmd.op = ctes_pkg::OP_STAT3;
            ctes_pkg::S_DX_INIT:       cmd.op = ctes_pkg::OP_DX_INIT;
            ctes_pkg::S_MUL_DX:        cmd.op = ctes_pkg::OP_MUL_STEP;
            ctes_pkg::S_DY_INIT:       cmd.op = ctes_pkg::OP_DY_INIT;
            ctes_pkg::S_MUL_DY:        cmd.op = ctes_pkg::OP_MUL_STEP;
            ctes_pkg::S_DIST_SUM:      cmd.op = ctes_pkg::OP_DIST_SUM;
            ctes_pkg::S_SQRT_DIST:     cmd.op = ctes_pkg::OP_SQRT_STEP;
            ctes_pkg::S_DIST_SAVE:     cmd.op = ctes_pkg::OP_DIST_SAVE;
            ctes_pkg::S_CLEAR:         cmd.op = ctes_pkg::OP_CLEAR;
            ctes_pkg::S_DEV:
            begin
                if (stat.count_zero)
                    cmd.op = ctes_pkg::OP_DEV_ZERO;
                else
                    cmd.op = ctes_pkg::OP_DEV_DIV_INIT;
            end
            ctes_pkg::S_DIV_DEV:       cmd.op = ctes_pkg::OP_DIV_STEP;
            ctes_pkg::S_SQRT_DEV_INIT: cmd.op = ctes_pkg::OP_DEV_SQRT_INIT;
            ctes_pkg::S_SQRT_DEV:      cmd.op = ctes_pkg::OP_SQRT_STEP;
            ctes_pkg::S_DEV_SAVE:      cmd.op = ctes_pkg::OP_DEV_SAVE;
            ctes_pkg::S_OUT:
            begin
                if (out_free)
                begin
                    cmd.op         = ctes_pkg::OP_OUT_LOAD;
                    out_valid_next = 1'b1;
                end
            end
            default:                   cmd.op = ctes_pkg::OP_IDLE;
        endcase
    end

endmodule

@@ hw/rtl/ctes_dp.sv @@
// datapath: cordic, shift-add multiplier, restoring divider, square root and statistics
module ctes_dp #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  ctes_pkg::cmd_t      cmd,
    output ctes_pkg::stat_t     stat,
    input  logic signed [31:0]  pose_x,
    input  logic signed [31:0]  pose_y,
    input  logic signed [31:0]  ref_x,
    input  logic signed [31:0]  ref_y,
    input  logic [15:0]         ref_heading,
    output logic signed [31:0]  last_error,
    output logic [30:0]         peak_abs_error,
    output logic signed [31:0]  mean_error,
    output logic [30:0]         deviation,
    output logic [31:0]         sign_flips,
    output logic [31:0]         sample_total,
    output logic [30:0]         target_distance
);

    localparam logic [COUNT_WIDTH-1:0] CMAX = '1;

    // input word
    logic signed [32:0] ex_reg, ey_reg;
    logic [15:0]        head_reg;

    // iteration counter
    logic [5:0] iter_reg;

    // cordic
    logic signed [33:0] cx_reg, cy_reg;
    logic signed [32:0] cz_reg;
    logic               flip_reg;

    // multiplier
    logic signed [35:0] ma_reg, mb_reg;
    logic [71:0]        acc_reg;
    logic               sub_reg;

    // divider
    logic [63:0] dvd_reg;
    logic [31:0] rem_reg;
    logic [31:0] dvs_reg;

    // square root
    logic [63:0] sv_reg, sres_reg;

    // statistics
    logic [30:0]            peak_reg;
    logic signed [31:0]     last_reg;
    logic signed [31:0]     mean_reg;
    logic [63:0]            spread_reg;
    logic [COUNT_WIDTH-1:0] count_reg;
    logic [31:0]            flips_reg;
    logic [1:0]             prior_reg;
    logic [30:0]            dist_reg;
    logic [30:0]            dev_reg;
    logic                   dneg_reg;
    logic [32:0]            m1_reg;
    logic [63:0]            sq_reg;
    logic                   dsat_reg;

    // output word
    logic signed [31:0] o_last_reg, o_mean_reg;
    logic [30:0]        o_peak_reg, o_dev_reg, o_dist_reg;
    logic [31:0]        o_flips_reg, o_count_reg;

    // combinational helpers
    logic                   flip_c;
    logic [31:0]            angle_c;
    logic signed [33:0]     xs_c, ys_c;
    logic signed [32:0]     at_c;
    logic [71:0]            part_c;
    logic                   neg_c;
    logic [63:0]            rnd_c;
    logic signed [33:0]     t34_c;
    logic signed [31:0]     cte_c;
    logic [31:0]            amag_c;
    logic [30:0]            amag31_c;
    logic [COUNT_WIDTH-1:0] n_c;
    logic [31:0]            n32_c;
    logic signed [32:0]     delta_c;
    logic [32:0]            m1_c;
    logic [32:0]            tdiv_c;
    logic                   qbit_c;
    logic signed [34:0]     q_c, mean35_c, nm_c;
    logic signed [35:0]     d2_c;
    logic [35:0]            m2_c;
    logic [63:0]            term_c;
    logic [64:0]            ssum_c;
    logic [1:0]             sgn_c;
    logic [32:0]            adx_c, ady_c;
    logic [64:0]            dsum_c;
    logic [5:0]             bsh_c;
    logic [63:0]            bit_c;
    logic [63:0]            rb_c;

    always_comb
    begin
        flip_c   = ref_heading[15] ^ ref_heading[14];
        angle_c  = {head_reg[15] ^ (head_reg[15] ^ head_reg[14]), head_reg[14:0], 16'h0000};
        xs_c     = cx_reg >>> iter_reg[4:0];
        ys_c     = cy_reg >>> iter_reg[4:0];
        at_c     = signed'({1'b0, ctes_pkg::atan_turn(iter_reg[4:0])});

        part_c   = mb_reg[iter_reg] ? (72'({{36{ma_reg[35]}}, ma_reg}) << iter_reg) : 72'd0;
        neg_c    = (iter_reg == 6'(ctes_pkg::MUL_STEPS - 1)) ^ sub_reg;

        rnd_c    = acc_reg[63:0] + 64'h0000_0000_2000_0000;
        t34_c    = signed'(rnd_c[63:30]);
        if (t34_c[33:31] == 3'b000 || t34_c[33:31] == 3'b111)
            cte_c = t34_c[31:0];
        else if (t34_c[33])
            cte_c = 32'sh8000_0000;
        else
            cte_c = 32'sh7FFF_FFFF;
        amag_c   = cte_c[31] ? 32'(-cte_c) : 32'(cte_c);
        amag31_c = (amag_c > 32'(ctes_pkg::MAX31)) ? ctes_pkg::MAX31 : amag_c[30:0];
        n_c      = (count_reg < CMAX) ? count_reg + 1'b1 : count_reg;
        n32_c    = 32'(n_c);
        delta_c  = 33'(cte_c) - 33'(mean_reg);
        m1_c     = delta_c[32] ? 33'(-delta_c) : 33'(delta_c);

        tdiv_c   = {rem_reg, dvd_reg[63]};
        qbit_c   = (tdiv_c >= 33'(dvs_reg));

        q_c      = signed'({1'b0, dvd_reg[33:0]});
        mean35_c = 35'(mean_reg);
        nm_c     = dneg_reg ? mean35_c - q_c : mean35_c + q_c;
        d2_c     = 36'(last_reg) - 36'(nm_c);
        m2_c     = d2_c[35] ? 36'(-d2_c) : 36'(d2_c);

        term_c   = (|acc_reg[71:64]) ? 64'hFFFF_FFFF_FFFF_FFFF : acc_reg[63:0];
        ssum_c   = 65'(spread_reg) + 65'(term_c);
        sgn_c    = last_reg[31] ? 2'd2 : 2'd1;

        adx_c    = ex_reg[32] ? 33'(-ex_reg) : 33'(ex_reg);
        ady_c    = ey_reg[32] ? 33'(-ey_reg) : 33'(ey_reg);
        dsum_c   = 65'(sq_reg) + 65'(acc_reg[63:0]);

        bsh_c    = 6'd62 - {iter_reg[4:0], 1'b0};
        bit_c    = 64'd1 << bsh_c;
        rb_c     = sres_reg + bit_c;
    end

    assign stat.cordic_last = (iter_reg == 6'(ctes_pkg::CORDIC_STEPS - 1));
    assign stat.mul_last    = (iter_reg == 6'(ctes_pkg::MUL_STEPS - 1));
    assign stat.div_last    = (iter_reg == 6'(ctes_pkg::DIV_STEPS - 1));
    assign stat.sqrt_last   = (iter_reg == 6'(ctes_pkg::SQRT_STEPS - 1));
    assign stat.count_zero  = (count_reg == '0);

    // iteration counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            iter_reg <= '0;
        else if (cmd.op == ctes_pkg::OP_CORDIC_STEP || cmd.op == ctes_pkg::OP_MUL_STEP ||
                 cmd.op == ctes_pkg::OP_DIV_STEP || cmd.op == ctes_pkg::OP_SQRT_STEP)
            iter_reg <= iter_reg + 6'd1;
        else
            iter_reg <= '0;
    end

    // statistics state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_reg   <= '0;
            last_reg   <= '0;
            mean_reg   <= '0;
            spread_reg <= '0;
            count_reg  <= '0;
            flips_reg  <= '0;
            prior_reg  <= '0;
            dist_reg   <= '0;
        end
        else
        begin
            case (cmd.op)
                ctes_pkg::OP_STAT1:
                begin
                    if (amag31_c > peak_reg)
                        peak_reg <= amag31_c;
                    last_reg  <= cte_c;
                    count_reg <= n_c;
                end
                ctes_pkg::OP_STAT2:
                begin
                    mean_reg <= nm_c[31:0];
                end
                ctes_pkg::OP_STAT3:
                begin
                    spread_reg <= ssum_c[64] ? 64'hFFFF_FFFF_FFFF_FFFF : ssum_c[63:0];
                    if (prior_reg != 2'd0 && sgn_c != prior_reg && flips_reg != 32'hFFFF_FFFF)
                        flips_reg <= flips_reg + 32'd1;
                    prior_reg <= sgn_c;
                end
                ctes_pkg::OP_DIST_SAVE:
                begin
                    dist_reg <= dsat_reg ? ctes_pkg::MAX31 : ctes_pkg::sat31(sres_reg);
                end
                ctes_pkg::OP_CLEAR:
                begin
                    peak_reg   <= '0;
                    last_reg   <= '0;
                    mean_reg   <= '0;
                    spread_reg <= '0;
                    count_reg  <= '0;
                    flips_reg  <= '0;
                    prior_reg  <= '0;
                    dist_reg   <= '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            ctes_pkg::OP_LOAD:
            begin
                ex_reg   <= 33'(pose_x) - 33'(ref_x);
                ey_reg   <= 33'(pose_y) - 33'(ref_y);
                head_reg <= ref_heading;
                flip_reg <= flip_c;
            end
            ctes_pkg::OP_CORDIC_INIT:
            begin
                cx_reg <= ctes_pkg::CORDIC_GAIN;
                cy_reg <= '0;
                cz_reg <= 33'(signed'(angle_c));
            end
            ctes_pkg::OP_CORDIC_STEP:
            begin
                if (!cz_reg[32])
                begin
                    cx_reg <= cx_reg - ys_c;
                    cy_reg <= cy_reg + xs_c;
                    cz_reg <= cz_reg - at_c;
                end
                else
                begin
                    cx_reg <= cx_reg + ys_c;
                    cy_reg <= cy_reg - xs_c;
                    cz_reg <= cz_reg + at_c;
                end
            end
            ctes_pkg::OP_MUL_A_INIT:
            begin
                ma_reg  <= flip_reg ? 36'(-cx_reg) : 36'(cx_reg);
                mb_reg  <= 36'(ey_reg);
                acc_reg <= '0;
                sub_reg <= 1'b0;
            end
            ctes_pkg::OP_MUL_B_INIT:
            begin
                ma_reg  <= flip_reg ? 36'(-cy_reg) : 36'(cy_reg);
                mb_reg  <= 36'(ex_reg);
                sub_reg <= 1'b1;
            end
            ctes_pkg::OP_MUL_STEP:
            begin
                acc_reg <= neg_c ? acc_reg - part_c : acc_reg + part_c;
            end
            ctes_pkg::OP_STAT1:
            begin
                dneg_reg <= delta_c[32];
                m1_reg   <= m1_c;
                dvd_reg  <= 64'(m1_c) + 64'(n32_c >> 1);
                dvs_reg  <= n32_c;
                rem_reg  <= '0;
            end
            ctes_pkg::OP_DIV_STEP:
            begin
                rem_reg <= qbit_c ? 32'(tdiv_c - 33'(dvs_reg)) : tdiv_c[31:0];
                dvd_reg <= {dvd_reg[62:0], qbit_c};
            end
            ctes_pkg::OP_STAT2:
            begin
                ma_reg  <= signed'(36'(m1_reg));
                mb_reg  <= signed'(m2_c);
                acc_reg <= '0;
                sub_reg <= 1'b0;
            end
            ctes_pkg::OP_DX_INIT:
            begin
                ma_reg  <= signed'(36'(adx_c));
                mb_reg  <= signed'(36'(adx_c));
                acc_reg <= '0;
                sub_reg <= 1'b0;
            end
            ctes_pkg::OP_DY_INIT:
            begin
                sq_reg  <= acc_reg[63:0];
                ma_reg  <= signed'(36'(ady_c));
                mb_reg  <= signed'(36'(ady_c));
                acc_reg <= '0;
                sub_reg <= 1'b0;
            end
            ctes_pkg::OP_DIST_SUM:
            begin
                dsat_reg <= dsum_c[64];
                sv_reg   <= dsum_c[63:0];
                sres_reg <= '0;
            end
            ctes_pkg::OP_SQRT_STEP:
            begin
                if (sv_reg >= rb_c)
                begin
                    sv_reg   <= sv_reg - rb_c;
                    sres_reg <= (sres_reg >> 1) + bit_c;
                end
                else
                begin
                    sres_reg <= sres_reg >> 1;
                end
            end
            ctes_pkg::OP_DEV_ZERO:
            begin
                dev_reg <= '0;
            end
            ctes_pkg::OP_DEV_DIV_INIT:
            begin
                dvd_reg <= spread_reg;
                dvs_reg <= 32'(count_reg);
                rem_reg <= '0;
            end
            ctes_pkg::OP_DEV_SQRT_INIT:
            begin
                sv_reg   <= dvd_reg;
                sres_reg <= '0;
            end
            ctes_pkg::OP_DEV_SAVE:
            begin
                dev_reg <= ctes_pkg::sat31(sres_reg);
            end
            ctes_pkg::OP_OUT_LOAD:
            begin
                o_last_reg  <= last_reg;
                o_peak_reg  <= peak_reg;
                o_mean_reg  <= mean_reg;
                o_dev_reg   <= dev_reg;
                o_flips_reg <= flips_reg;
                o_count_reg <= 32'(count_reg);
                o_dist_reg  <= dist_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign last_error      = o_last_reg;
    assign peak_abs_error  = o_peak_reg;
    assign mean_error      = o_mean_reg;
    assign deviation       = o_dev_reg;
    assign sign_flips      = o_flips_reg;
    assign sample_total    = o_count_reg;
    assign target_distance = o_dist_reg;

endmodule

@@ hw/rtl/cross_track_error_statistics.sv @@
// top level of the cross-track error statistics block
//
// input channel: in_valid / in_stall carry one word of mode, pose, reference point
// and heading; output channel: out_valid / out_stall carry one result word per input
// word with the statistics as they stand after that word
// mode update: cordic sine/cosine, two 36-step shift-add multiplies, a 64-step
// restoring divide for the mean, a third multiply, then the deviation (64-step divide
// of m2 by the count and a 32-step square root)
// mode distance: two multiplies and a square root, plus the deviation
// unused mode: the deviation only; clear: wipes the statistics, then the deviation
// one word is in work at a time; the iterative units set the rate
// the result sits in an output register, so the next word is taken while it waits;
// a word that finishes while the previous result is still stalled holds until it
// is taken
// reset clears all statistics and the output valid flag; no clearing pass is needed
module cross_track_error_statistics #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         mode,
    input  logic signed [31:0] pose_x,
    input  logic signed [31:0] pose_y,
    input  logic signed [31:0] ref_x,
    input  logic signed [31:0] ref_y,
    input  logic [15:0]        ref_heading,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] last_error,
    output logic [30:0]        peak_abs_error,
    output logic signed [31:0] mean_error,
    output logic [30:0]        deviation,
    output logic [31:0]        sign_flips,
    output logic [31:0]        sample_total,
    output logic [30:0]        target_distance
);

    ctes_pkg::cmd_t  cmd;
    ctes_pkg::stat_t stat;

    ctes_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .mode      (mode),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    ctes_dp #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .pose_x          (pose_x),
        .pose_y          (pose_y),
        .ref_x           (ref_x),
        .ref_y           (ref_y),
        .ref_heading     (ref_heading),
        .last_error      (last_error),
        .peak_abs_error  (peak_abs_error),
        .mean_error      (mean_error),
        .deviation       (deviation),
        .sign_flips      (sign_flips),
        .sample_total    (sample_total),
        .target_distance (target_distance)
    );

endmodule

@@ test/tb_cross_track_error_statistics.sv @@
// self-checking testbench for the cross-track error statistics block
`timescale 1ns / 100ps

module tb_cross_track_error_statistics;

    localparam int STALL_LIMIT = 8000;
    localparam int RANDOM_WORDS = 630;
    localparam logic [30:0] PEAK31 = 31'h7FFF_FFFF;

    typedef struct {
        ctes_pkg::mode_t    op;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] rx;
        logic signed [31:0] ry;
        logic [15:0]        hdg;
    } pose_word_t;

    typedef struct {
        logic signed [31:0] last;
        logic [30:0]        peak;
        logic signed [31:0] mean;
        logic [30:0]        dev;
        logic [31:0]        flips;
        logic [31:0]        total;
        logic [30:0]        tdist;
    } stats_word_t;

    typedef struct {
        pose_word_t  w;
        bit          typed;
        stats_word_t want;
    } plan_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [1:0] mode = ctes_pkg::MODE_NONE;
    logic signed [31:0] pose_x = '0, pose_y = '0, ref_x = '0, ref_y = '0;
    logic [15:0] ref_heading = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [31:0] last_error, mean_error;
    logic [30:0] peak_abs_error, deviation, target_distance;
    logic [31:0] sign_flips, sample_total;

    cross_track_error_statistics DUT (.*);

    always #5 clk = ~clk;

    // predictor state
    logic [30:0]        peak_q;
    logic signed [31:0] last_q;
    logic signed [31:0] mean_q;
    logic [63:0]        m2_q;
    logic [31:0]        count_q;
    logic [31:0]        flips_q;
    logic [1:0]         sign_q;
    logic [30:0]        dist_q;

    logic [31:0] atan_tab [30] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
        32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
        32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
    };

    stats_word_t stats_pending [$];
    int errors = 0;
    int n_upd = 0, n_dist = 0, n_clr = 0, n_out = 0;
    int idle_cnt = 0;
    bit quiet = 1'b0;

    function automatic logic [63:0] root_floor(input logic [63:0] v);
        logic [63:0] res, b;
        res = '0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic logic signed [31:0] heading_cross(input longint ex, input longint ey,
                                                         input logic [15:0] h);
        logic [31:0] ang;
        bit turned;
        longint x, y, z, t, acc;
        ang = {h, 16'h0000};
        turned = (h[15:14] == 2'd1) || (h[15:14] == 2'd2);
        if (turned)
            ang = ang + 32'h8000_0000;
        z = longint'(signed'(ang));
        x = 64'sd652032874;
        y = 0;
        for (int i = 0; i < 30; i++)
        begin
            if (z >= 0)
            begin
                t = x - (y >>> i);
                y = y + (x >>> i);
                z = z - longint'(atan_tab[i]);
            end
            else
            begin
                t = x + (y >>> i);
                y = y - (x >>> i);
                z = z + longint'(atan_tab[i]);
            end
            x = t;
        end
        if (turned)
        begin
            x = -x;
            y = -y;
        end
        acc = x * ey - y * ex + (64'sd1 <<< 29);
        acc = acc >>> 30;
        if (acc > 64'sd2147483647)
            acc = 64'sd2147483647;
        if (acc < -64'sd2147483648)
            acc = -64'sd2147483648;
        return acc[31:0];
    endfunction

    function automatic logic [63:0] mag(input longint v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    function automatic void track_error(input logic signed [31:0] cte);
        logic [63:0] amag, n, m1, m2, q, term;
        logic [127:0] prod;
        logic [64:0] sum;
        longint dlt, nm;
        logic [1:0] sg;
        amag = mag(longint'(cte));
        if (amag > 64'(PEAK31))
            amag = 64'(PEAK31);
        if (amag[30:0] > peak_q)
            peak_q = amag[30:0];
        last_q = cte;
        if (count_q != 32'hFFFF_FFFF)
            count_q = count_q + 1;
        n = 64'(count_q);
        dlt = longint'(cte) - longint'(mean_q);
        m1 = mag(dlt);
        q = (m1 + n / 2) / n;
        nm = (dlt < 0) ? longint'(mean_q) - longint'(q) : longint'(mean_q) + longint'(q);
        mean_q = nm[31:0];
        m2 = mag(longint'(cte) - nm);
        prod = 128'(m1) * 128'(m2);
        term = (prod[127:64] != 0) ? '1 : prod[63:0];
        sum = 65'(m2_q) + 65'(term);
        m2_q = sum[64] ? '1 : sum[63:0];
        sg = (cte >= 0) ? 2'd1 : 2'd2;
        if (sign_q != 0 && sg != sign_q && flips_q != 32'hFFFF_FFFF)
            flips_q = flips_q + 1;
        sign_q = sg;
    endfunction

    function automatic void wipe_stats();
        peak_q = '0; last_q = '0; mean_q = '0; m2_q = '0;
        count_q = '0; flips_q = '0; sign_q = '0; dist_q = '0;
    endfunction

    function automatic stats_word_t step_stats(input pose_word_t w);
        stats_word_t r;
        longint dx, dy;
        logic [63:0] a, b, s, rt;
        dx = longint'(w.px) - longint'(w.rx);
        dy = longint'(w.py) - longint'(w.ry);
        case (w.op)
            ctes_pkg::MODE_UPDATE: track_error(heading_cross(dx, dy, w.hdg));
            ctes_pkg::MODE_DIST:
            begin
                a = mag(dx) * mag(dx);
                b = mag(dy) * mag(dy);
                s = a + b;
                if (s < a)
                    dist_q = PEAK31;
                else
                begin
                    rt = root_floor(s);
                    dist_q = (rt > 64'(PEAK31)) ? PEAK31 : rt[30:0];
                end
            end
            ctes_pkg::MODE_CLEAR: wipe_stats();
            default: ;
        endcase
        r.dev = '0;
        if (count_q != 0)
        begin
            rt = root_floor(m2_q / 64'(count_q));
            r.dev = (rt > 64'(PEAK31)) ? PEAK31 : rt[30:0];
        end
        r.last = last_q; r.peak = peak_q; r.mean = mean_q;
        r.flips = flips_q; r.total = count_q; r.tdist = dist_q;
        return r;
    endfunction

    task automatic report(input string fld, input logic [31:0] got, input logic [31:0] want);
        errors++;
        $display("[%0t] %s: got %h, want %h", $time, fld, got, want);
    endtask

    // result side
    always @(posedge clk)
    begin
        stats_word_t e;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                n_out++;
                if (stats_pending.size() == 0)
                    report("unexpected word", last_error, 32'h0);
                else
                begin
                    e = stats_pending.pop_front();
                    if (last_error !== e.last) report("last_error", last_error, e.last);
                    if (peak_abs_error !== e.peak)
                        report("peak_abs_error", 32'(peak_abs_error), 32'(e.peak));
                    if (mean_error !== e.mean) report("mean_error", mean_error, e.mean);
                    if (deviation !== e.dev)
                        report("deviation", 32'(deviation), 32'(e.dev));
                    if (sign_flips !== e.flips) report("sign_flips", sign_flips, e.flips);
                    if (sample_total !== e.total) report("sample_total", sample_total, e.total);
                    if (target_distance !== e.tdist)
                        report("target_distance", 32'(target_distance), 32'(e.tdist));
                end
            end
            out_stall <= !quiet && ($urandom_range(99) < 7);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cnt <= 0;
        else
            idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= STALL_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic send_word(input pose_word_t w, input bit typed, input stats_word_t want);
        stats_word_t p;
        mode <= w.op; pose_x <= w.px; pose_y <= w.py;
        ref_x <= w.rx; ref_y <= w.ry; ref_heading <= w.hdg;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        p = step_stats(w);
        stats_pending.push_back(typed ? want : p);
        case (w.op)
            ctes_pkg::MODE_UPDATE: n_upd++;
            ctes_pkg::MODE_DIST: n_dist++;
            ctes_pkg::MODE_CLEAR: n_clr++;
            default: ;
        endcase
        if (!quiet && $urandom_range(99) < 7)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
    endtask

    function automatic logic signed [31:0] coord();
        case ($urandom_range(3))
            0: return $urandom;
            1: return 32'($urandom_range(2000)) - 32'sd1000;
            default: return 32'($urandom_range(20 << 16)) - 32'sd655360;
        endcase
    endfunction

    function automatic pose_word_t rand_word();
        pose_word_t w;
        int pick;
        pick = $urandom_range(99);
        w.op = (pick < 72) ? ctes_pkg::MODE_UPDATE : (pick < 90) ? ctes_pkg::MODE_DIST :
               (pick < 95) ? ctes_pkg::MODE_CLEAR : ctes_pkg::MODE_NONE;
        w.rx = coord(); w.ry = coord();
        if ($urandom_range(3) == 0)
        begin
            w.px = $urandom; w.py = $urandom;
        end
        else
        begin
            w.px = w.rx + (32'($urandom_range(8 << 16)) - 32'sd262144);
            w.py = w.ry + (32'($urandom_range(8 << 16)) - 32'sd262144);
        end
        w.hdg = 16'($urandom);
        return w;
    endfunction

    plan_row_t plan [] = '{
        '{'{ctes_pkg::MODE_CLEAR, 0, 0, 0, 0, 16'h0000}, 1, '{0, 0, 0, 0, 0, 0, 0}},
        '{'{ctes_pkg::MODE_NONE, -1, -1, -1, -1, 16'hFFFF}, 1, '{0, 0, 0, 0, 0, 0, 0}},
        '{'{ctes_pkg::MODE_DIST, 32'sd196608, 32'sd262144, 0, 0, 16'h0}, 1,
          '{0, 0, 0, 0, 0, 0, 31'd327680}},
        '{'{ctes_pkg::MODE_UPDATE, 0, 32'sd65536, 0, 0, 16'h0000}, 0,
          '{0, 0, 0, 0, 0, 0, 0}},
        '{'{ctes_pkg::MODE_UPDATE, 0, -32'sd65536, 0, 0, 16'h0000}, 0,
          '{0, 0, 0, 0, 0, 0, 0}},
        '{'{ctes_pkg::MODE_UPDATE, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 16'h4000}, 0,
          '{0, 0, 0, 0, 0, 0, 0}},
        '{'{ctes_pkg::MODE_UPDATE, 32'sd65536, 0, 0, 0, 16'h4000}, 0,
          '{0, 0, 0, 0, 0, 0, 0}},
        '{'{ctes_pkg::MODE_UPDATE, 0, 32'sd131072, 0, 0, 16'h8000}, 0,
          '{0, 0, 0, 0, 0, 0, 0}},
        '{'{ctes_pkg::MODE_UPDATE, 32'sd65536, 32'sd65536, 0, 0, 16'hC000}, 0,
          '{0, 0, 0, 0, 0, 0, 0}},
        '{'{ctes_pkg::MODE_UPDATE, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000,
            16'h2000}, 0, '{0, 0, 0, 0, 0, 0, 0}},
        '{'{ctes_pkg::MODE_UPDATE, 32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
            16'h2000}, 0, '{0, 0, 0, 0, 0, 0, 0}},
        '{'{ctes_pkg::MODE_UPDATE, 32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000,
            16'hBFFF}, 0, '{0, 0, 0, 0, 0, 0, 0}},
        '{'{ctes_pkg::MODE_UPDATE, 5, 7, 3, 2, 16'h7FFF}, 0, '{0, 0, 0, 0, 0, 0, 0}},
        '{'{ctes_pkg::MODE_DIST, 32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
            16'h0}, 0, '{0, 0, 0, 0, 0, 0, 0}},
        '{'{ctes_pkg::MODE_DIST, 32'sh80000000, 0, 32'sh7FFFFFFF, 0, 16'h0}, 0,
          '{0, 0, 0, 0, 0, 0, 0}},
        '{'{ctes_pkg::MODE_DIST, 32'sh7FFFFFFF, 0, 32'sh7FFFFFFF, 0, 16'h0}, 0,
          '{0, 0, 0, 0, 0, 0, 0}},
        '{'{ctes_pkg::MODE_NONE, 1, 2, 3, 4, 16'h1234}, 0, '{0, 0, 0, 0, 0, 0, 0}},
        '{'{ctes_pkg::MODE_UPDATE, 32'sd40000, -32'sd90000, 0, 0, 16'hE000}, 0,
          '{0, 0, 0, 0, 0, 0, 0}},
        '{'{ctes_pkg::MODE_CLEAR, 1, 1, 1, 1, 16'h1}, 0, '{0, 0, 0, 0, 0, 0, 0}},
        '{'{ctes_pkg::MODE_UPDATE, 32'sd1000, 32'sd1000, 0, 0, 16'h6000}, 0,
          '{0, 0, 0, 0, 0, 0, 0}}
    };

    initial
    begin
        stats_word_t none;
        none = '{0, 0, 0, 0, 0, 0, 0};
        wipe_stats();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (plan[i])
            send_word(plan[i].w, plan[i].typed, plan[i].want);
        for (int k = 0; k < RANDOM_WORDS; k++)
        begin
            quiet = (k >= 200 && k < 330);
            send_word(rand_word(), 1'b0, none);
        end
        quiet = 1'b0;
        in_valid <= 1'b0;
        while (stats_pending.size() != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
        $display("words sent: %0d update, %0d distance, %0d clear; results checked: %0d",
                 n_upd, n_dist, n_clr, n_out);
        $display("random poses over full range and near path, all heading quadrants");
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/ctes_pkg.sv
hw/rtl/ctes_ctrl.sv
hw/rtl/ctes_dp.sv
hw/rtl/cross_track_error_statistics.sv
test/tb_cross_track_error_statistics.sv
